// ----- rtl/core/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int DATA_W         = 32;
    localparam int TOKEN_W        = 8;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    // Character codes
    localparam logic [TOKEN_W-1:0] TOK_ADD = 8'h2B;
    localparam logic [TOKEN_W-1:0] TOK_SUB = 8'h2D;
    localparam logic [TOKEN_W-1:0] TOK_MUL = 8'h2A;
    localparam logic [TOKEN_W-1:0] TOK_DIV = 8'h2F;
    localparam logic [TOKEN_W-1:0] TOK_END = 8'h23;

    // Bit positions in the sticky error flags
    localparam int FLAG_DIV_BIT = 0;
    localparam int FLAG_OVF_BIT = 1;
    localparam int FLAG_UNF_BIT = 2;
    localparam int FLAG_W       = 3;

    typedef enum logic [2:0] {
        KIND_OPND,
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV,
        KIND_END
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t           kind;
        logic [TOKEN_W-1:0]  value;
    } queue_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_L,
        ST_CALC,
        ST_DIV,
        ST_EMIT
    } exec_state_t;

endpackage

// ----- rtl/core/pfe_front.sv -----
// ----------------------------------------------------------------------------
// pfe_front
// Accepts tokens, classifies them and holds them in a short queue for the
// execution back end.
// ----------------------------------------------------------------------------
module pfe_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_token,
    output logic                      q_valid,
    output pfe_pkg::queue_entry_t     q_entry,
    input  logic                      q_pop
);
    import pfe_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t       entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]     count_reg, count_next;
    queue_entry_t       new_entry;
    logic               push, pop;

    always_comb begin
        new_entry.value = s_token;
        priority case (s_token)
            TOK_ADD: new_entry.kind = KIND_ADD;
            TOK_SUB: new_entry.kind = KIND_SUB;
            TOK_MUL: new_entry.kind = KIND_MUL;
            TOK_DIV: new_entry.kind = KIND_DIV;
            TOK_END: new_entry.kind = KIND_END;
            default: new_entry.kind = KIND_OPND;
        endcase
    end

    assign s_ready = (count_reg != QCW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

// ----- rtl/core/pfe_div.sv -----
// ----------------------------------------------------------------------------
// pfe_div
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per
// cycle. done pulses for one cycle when quotient is valid.
// ----------------------------------------------------------------------------
module pfe_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pfe_pkg::DATA_W-1:0] dividend,
    input  logic [pfe_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [pfe_pkg::DATA_W-1:0] quotient
);
    import pfe_pkg::*;

    localparam int SW = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   shifted, diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/pfe_exec.sv -----
// ----------------------------------------------------------------------------
// pfe_exec
// Back end: runs queued tokens against the operand stack memory, drives the
// divider and holds the result register.
// ----------------------------------------------------------------------------
module pfe_exec #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  pfe_pkg::queue_entry_t         q_entry,
    output logic                          q_pop,
    output logic                          div_start,
    output logic [pfe_pkg::DATA_W-1:0]    div_dividend,
    output logic [pfe_pkg::DATA_W-1:0]    div_divisor,
    input  logic                          div_done,
    input  logic [pfe_pkg::DATA_W-1:0]    div_quotient,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [pfe_pkg::DATA_W-1:0] m_value,
    output logic                          m_div_by_zero,
    output logic                          m_stack_overflow,
    output logic                          m_stack_underflow
);
    import pfe_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    exec_state_t       state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic              started_reg, started_next;
    tok_kind_t         op_reg, op_next;
    logic              r_empty_reg, r_empty_next;
    logic              l_empty_reg, l_empty_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;
    logic [FLAG_W-1:0] m_flags_reg, m_flags_next;

    logic [CW-1:0]     cnt_m1;
    logic [AW-1:0]     raddr;
    logic              cnt_empty;
    logic              out_free;
    logic [DATA_W-1:0] l_val;
    logic              push_req;
    logic [DATA_W-1:0] push_val;
    logic              wr_en;

    // Read address always tracks the top; rdata_reg is the registered read of it.
    assign cnt_m1    = cnt_reg - 1'b1;
    assign raddr     = cnt_m1[AW-1:0];
    assign cnt_empty = (cnt_reg == '0);
    assign out_free  = !m_valid_reg || m_ready;
    assign l_val     = l_empty_reg ? '0 : rdata_reg;

    assign div_dividend = l_val[DATA_W-1] ? (DATA_W'(0) - l_val) : l_val;
    assign div_divisor  = r_reg[DATA_W-1] ? (DATA_W'(0) - r_reg) : r_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        flags_next   = flags_reg;
        started_next = started_reg;
        op_next      = op_reg;
        r_empty_next = r_empty_reg;
        l_empty_next = l_empty_reg;
        neg_next     = neg_reg;
        r_next       = r_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_flags_next = m_flags_reg;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        push_req     = 1'b0;
        push_val     = '0;
        wr_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    unique case (q_entry.kind)
                        KIND_OPND: begin
                            started_next = 1'b1;
                            push_req     = 1'b1;
                            push_val     = DATA_W'(q_entry.value);
                        end
                        KIND_END: begin
                            // terminator with no expression is dropped
                            if (started_reg) begin
                                state_next = ST_EMIT;
                            end
                        end
                        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                            started_next = 1'b1;
                            op_next      = q_entry.kind;
                            if (cnt_empty) begin
                                flags_next[FLAG_UNF_BIT] = 1'b1;
                                r_empty_next = 1'b1;
                            end else begin
                                cnt_next     = cnt_m1;
                                r_empty_next = 1'b0;
                            end
                            state_next = ST_POP_L;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP_L: begin
                r_next = r_empty_reg ? '0 : rdata_reg;
                if (cnt_empty) begin
                    flags_next[FLAG_UNF_BIT] = 1'b1;
                    l_empty_next = 1'b1;
                end else begin
                    cnt_next     = cnt_m1;
                    l_empty_next = 1'b0;
                end
                state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ST_IDLE;
                unique case (op_reg)
                    KIND_ADD: begin
                        push_req = 1'b1;
                        push_val = l_val + r_reg;
                    end
                    KIND_SUB: begin
                        push_req = 1'b1;
                        push_val = l_val - r_reg;
                    end
                    KIND_MUL: begin
                        push_req = 1'b1;
                        push_val = l_val * r_reg;
                    end
                    KIND_DIV: begin
                        if (r_reg == '0) begin
                            flags_next[FLAG_DIV_BIT] = 1'b1;
                            push_req = 1'b1;
                            push_val = '0;
                        end else begin
                            div_start  = 1'b1;
                            neg_next   = l_val[DATA_W-1] ^ r_reg[DATA_W-1];
                            state_next = ST_DIV;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    push_req   = 1'b1;
                    push_val   = neg_reg ? (DATA_W'(0) - div_quotient) : div_quotient;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = cnt_empty ? '0 : rdata_reg;
                    m_flags_next = flags_reg;
                    cnt_next     = '0;
                    flags_next   = '0;
                    started_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // push never coincides with a pop, so cnt_reg is current here
        if (push_req) begin
            if (cnt_reg == CW'(STACK_DEPTH)) begin
                flags_next[FLAG_OVF_BIT] = 1'b1;
            end else begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            flags_reg   <= '0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            flags_reg   <= flags_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        r_empty_reg <= r_empty_next;
        l_empty_reg <= l_empty_next;
        neg_reg     <= neg_next;
        r_reg       <= r_next;
        m_value_reg <= m_value_next;
        m_flags_reg <= m_flags_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[cnt_reg[AW-1:0]] <= push_val;
        end
        rdata_reg <= stack_mem[raddr];
    end

    assign m_valid           = m_valid_reg;
    assign m_value           = m_value_reg;
    assign m_div_by_zero     = m_flags_reg[FLAG_DIV_BIT];
    assign m_stack_overflow  = m_flags_reg[FLAG_OVF_BIT];
    assign m_stack_underflow = m_flags_reg[FLAG_UNF_BIT];

endmodule

// ----- rtl/core/postfix_expression_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Postfix evaluator on a 32-bit signed operand stack, one token per transaction.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   token   | s_valid s_ready s_token                 | in
//   result  | m_valid m_ready m_value m_div_by_zero   | out
//           | m_stack_overflow m_stack_underflow      |
//
// Back end per token: operand IDLE; + - * IDLE, POP_L, CALC; / adds DIV (32-step
// radix-2 divider); '#' IDLE, EMIT plus any wait on the result register.
// A two-entry queue lets the front take tokens while the back end works.
// aresetn is synchronous; it clears control state only. Stack contents are
// not cleared and are never used before being written.
// A result waiting in the output register stalls only the next '#'.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_token,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pfe_pkg::DATA_W-1:0] m_value,
    output logic                              m_div_by_zero,
    output logic                              m_stack_overflow,
    output logic                              m_stack_underflow
);
    import pfe_pkg::*;

    logic              q_valid;
    queue_entry_t      q_entry;
    logic              q_pop;
    logic              div_start;
    logic [DATA_W-1:0] div_dividend;
    logic [DATA_W-1:0] div_divisor;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;

    pfe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_token (s_token),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    pfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    pfe_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_entry           (q_entry),
        .q_pop             (q_pop),
        .div_start         (div_start),
        .div_dividend      (div_dividend),
        .div_divisor       (div_divisor),
        .div_done          (div_done),
        .div_quotient      (div_quotient),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_value           (m_value),
        .m_div_by_zero     (m_div_by_zero),
        .m_stack_overflow  (m_stack_overflow),
        .m_stack_underflow (m_stack_underflow)
    );

endmodule
